@@ hw/rtl/a64rel_pkg.sv @@
`default_nettype none

package a64rel_pkg;

    // instruction classes as reported on the result channel
    typedef enum logic [2:0] {
        CLS_OTHER   = 3'd0,
        CLS_B_BL    = 3'd1,
        CLS_B_COND  = 3'd2,
        CLS_CBZ     = 3'd3,
        CLS_TBZ     = 3'd4,
        CLS_ADR     = 3'd5,
        CLS_ADRP    = 3'd6,
        CLS_LDR_LIT = 3'd7
    } insn_class_t;

    // decode masks and match values
    localparam logic [31:0] B_BL_MASK    = 32'h7C00_0000;
    localparam logic [31:0] B_BL_MATCH   = 32'h1400_0000;
    localparam logic [31:0] B_COND_MASK  = 32'hFF00_0010;
    localparam logic [31:0] B_COND_MATCH = 32'h5400_0000;
    localparam logic [31:0] CB_TB_MASK   = 32'h7E00_0000;
    localparam logic [31:0] CBZ_MATCH    = 32'h3400_0000;
    localparam logic [31:0] TBZ_MATCH    = 32'h3600_0000;
    localparam logic [31:0] ADR_MASK     = 32'h9F00_0000;
    localparam logic [31:0] ADR_MATCH    = 32'h1000_0000;
    localparam logic [31:0] ADRP_MATCH   = 32'h9000_0000;
    localparam logic [31:0] LDR_LIT_MASK  = 32'h3B00_0000;
    localparam logic [31:0] LDR_LIT_MATCH = 32'h1800_0000;

    localparam logic [63:0] PAGE_MASK = 64'hFFFF_FFFF_FFFF_F000;

    // one relocated result beat
    typedef struct packed {
        logic [31:0] word;
        logic        ok;
        insn_class_t cls;
    } reloc_result_t;

endpackage : a64rel_pkg

`default_nettype wire

@@ hw/rtl/arm64_pc_relative_relocator.sv @@
// AArch64 PC-relative instruction relocator.
// Input channel (s_*): one instruction word with the address it was linked at
// and the address it will be placed at, per beat. Result channel (m_*): the
// re-encoded word, an ok flag and the decoded instruction class, one beat per
// input beat, in order.
// Branches, compare/test branches, load literal, ADR and ADRP get their
// offset field rewritten so they reach the same target; any other word
// passes through with ok set. A target out of reach, or misaligned for a
// branch or load literal, gives ok low and a zero word.
// An input beat goes into the input register, then through decode, 64-bit
// offset arithmetic and range check into the result register.
// Throughput: one beat per cycle across the two register stages while the
// receiver keeps m_ready high.
// Reset (aresetn low, synchronous) empties both stages; nothing is in flight
// after it. When the receiver stalls, the result register holds its beat and
// the input register can still take one more beat; s_ready drops only once
// both stages are full.
`default_nettype none

module arm64_pc_relative_relocator
    import a64rel_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output wire logic        s_ready,
    input  wire logic [31:0] s_instr_word,
    input  wire logic [63:0] s_old_address,
    input  wire logic [63:0] s_new_address,

    output wire logic        m_valid,
    input  wire logic        m_ready,
    output wire logic [31:0] m_relocated_word,
    output wire logic        m_ok,
    output wire logic [2:0]  m_insn_class
);

    // input stage
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] word_reg;
    logic [63:0] old_addr_reg;
    logic [63:0] new_addr_reg;

    // result stage
    logic          out_valid_reg;
    logic          out_valid_next;
    reloc_result_t result_reg;
    reloc_result_t result_next;

    logic out_load;
    logic in_load;

    // result stage takes a beat when empty or being drained this cycle
    assign out_load = !out_valid_reg || m_ready;
    // input stage takes a beat when empty or passing its beat on
    assign in_load  = !in_valid_reg || out_load;
    assign s_ready  = in_load;

    assign in_valid_next  = in_load ? s_valid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    // decode and re-encode between the two stages
    a64rel_core u_core (
        .instr_word  (word_reg),
        .old_address (old_addr_reg),
        .new_address (new_addr_reg),
        .result      (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (in_load && s_valid) begin
            word_reg     <= s_instr_word;
            old_addr_reg <= s_old_address;
            new_addr_reg <= s_new_address;
        end
        if (out_load && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_relocated_word = result_reg.word;
    assign m_ok             = result_reg.ok;
    assign m_insn_class     = result_reg.cls;

endmodule : arm64_pc_relative_relocator

`default_nettype wire

@@ hw/rtl/a64rel_core.sv @@
`default_nettype none

module a64rel_core
    import a64rel_pkg::*;
(
    input  wire logic [31:0]   instr_word,
    input  wire logic [63:0]   old_address,
    input  wire logic [63:0]   new_address,
    output reloc_result_t      result
);

    insn_class_t cls;
    logic [63:0] offset;
    logic [63:0] old_base;
    logic [63:0] new_base;
    logic [63:0] delta;
    logic        in_range;
    logic        aligned;
    logic [31:0] word;
    logic        ok;

    // decode, first match wins
    always_comb begin
        if ((instr_word & B_BL_MASK) == B_BL_MATCH) begin
            cls = CLS_B_BL;
        end else if ((instr_word & B_COND_MASK) == B_COND_MATCH) begin
            cls = CLS_B_COND;
        end else if ((instr_word & CB_TB_MASK) == CBZ_MATCH) begin
            cls = CLS_CBZ;
        end else if ((instr_word & LDR_LIT_MASK) == LDR_LIT_MATCH) begin
            cls = CLS_LDR_LIT;
        end else if ((instr_word & CB_TB_MASK) == TBZ_MATCH) begin
            cls = CLS_TBZ;
        end else if ((instr_word & ADR_MASK) == ADR_MATCH) begin
            cls = CLS_ADR;
        end else if ((instr_word & ADR_MASK) == ADRP_MATCH) begin
            cls = CLS_ADRP;
        end else begin
            cls = CLS_OTHER;
        end
    end

    // sign-extended byte offset encoded in the word
    always_comb begin
        case (cls)
            CLS_B_BL: begin
                offset = {{36{instr_word[25]}}, instr_word[25:0], 2'b00};
            end
            CLS_B_COND, CLS_CBZ, CLS_LDR_LIT: begin
                offset = {{43{instr_word[23]}}, instr_word[23:5], 2'b00};
            end
            CLS_TBZ: begin
                offset = {{48{instr_word[18]}}, instr_word[18:5], 2'b00};
            end
            CLS_ADR: begin
                offset = {{43{instr_word[23]}}, instr_word[23:5], instr_word[30:29]};
            end
            CLS_ADRP: begin
                offset = {{31{instr_word[23]}}, instr_word[23:5], instr_word[30:29],
                          12'h000};
            end
            default: begin
                offset = 64'd0;
            end
        endcase
    end

    // adrp works on page bases only
    assign old_base = (cls == CLS_ADRP) ? (old_address & PAGE_MASK) : old_address;
    assign new_base = (cls == CLS_ADRP) ? (new_address & PAGE_MASK) : new_address;
    assign delta    = old_base + offset - new_base;

    assign aligned = (delta[1:0] == 2'b00);

    // signed range: all bits from the top down to the field sign bit agree
    always_comb begin
        case (cls)
            CLS_B_BL: begin
                in_range = (&delta[63:27]) || !(|delta[63:27]);
            end
            CLS_B_COND, CLS_CBZ, CLS_LDR_LIT, CLS_ADR: begin
                in_range = (&delta[63:20]) || !(|delta[63:20]);
            end
            CLS_TBZ: begin
                in_range = (&delta[63:15]) || !(|delta[63:15]);
            end
            CLS_ADRP: begin
                in_range = (&delta[63:32]) || !(|delta[63:32]);
            end
            default: begin
                in_range = 1'b1;
            end
        endcase
    end

    // re-encode, every bit outside the offset field kept
    always_comb begin
        case (cls)
            CLS_B_BL: begin
                word = {instr_word[31:26], delta[27:2]};
                ok   = in_range && aligned;
            end
            CLS_B_COND, CLS_CBZ, CLS_LDR_LIT: begin
                word = {instr_word[31:24], delta[20:2], instr_word[4:0]};
                ok   = in_range && aligned;
            end
            CLS_TBZ: begin
                word = {instr_word[31:19], delta[15:2], instr_word[4:0]};
                ok   = in_range && aligned;
            end
            CLS_ADR: begin
                word = {instr_word[31], delta[1:0], instr_word[28:24], delta[20:2],
                        instr_word[4:0]};
                ok   = in_range;
            end
            CLS_ADRP: begin
                word = {instr_word[31], delta[13:12], instr_word[28:24], delta[32:14],
                        instr_word[4:0]};
                ok   = in_range;
            end
            default: begin
                word = instr_word;
                ok   = 1'b1;
            end
        endcase
    end

    assign result = '{word: (ok ? word : 32'd0), ok: ok, cls: cls};

endmodule : a64rel_core

`default_nettype wire

@@ hw/rtl/a64rel_checker.sv @@
`default_nettype none

module a64rel_checker
    import a64rel_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_relocated_word,
    input wire logic        m_ok,
    input wire logic [2:0]  m_insn_class
);

    // reset leaves nothing in flight
    property p_reset_empties;
        @(posedge aclk) !aresetn |=> !m_valid;
    endproperty
    a_reset_empties: assert property (p_reset_empties)
        else $error("result valid right after reset");

    // a stalled result beat holds
    property p_stall_holds;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_relocated_word)
            && $stable(m_ok) && $stable(m_insn_class);
    endproperty
    a_stall_holds: assert property (p_stall_holds)
        else $error("stalled result beat changed");

    // failed relocation carries a zero word
    property p_fail_zero;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_relocated_word == 32'd0;
    endproperty
    a_fail_zero: assert property (p_fail_zero)
        else $error("failed relocation with nonzero word");

    // a word that is not pc-relative never fails
    property p_other_ok;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_insn_class == CLS_OTHER |-> m_ok;
    endproperty
    a_other_ok: assert property (p_other_ok)
        else $error("pass-through word flagged as failed");

    // with the result side free, input is never refused
    property p_no_refuse;
        @(posedge aclk) disable iff (!aresetn)
        s_valid && !m_valid |-> s_ready;
    endproperty
    a_no_refuse: assert property (p_no_refuse)
        else $error("input refused while result stage empty");

endmodule : a64rel_checker

bind arm64_pc_relative_relocator a64rel_checker u_a64rel_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_relocated_word (m_relocated_word),
    .m_ok             (m_ok),
    .m_insn_class     (m_insn_class)
);

`default_nettype wire

@@ tb/tb_arm64_pc_relative_relocator.sv @@
`timescale 1ns / 1ps

module tb_arm64_pc_relative_relocator;
    import a64rel_pkg::*;

    // clock, reset and both channels; every input starts at a known value
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    wire         s_ready;
    logic [31:0] s_instr_word  = '0;
    logic [63:0] s_old_address = '0;
    logic [63:0] s_new_address = '0;
    wire         m_valid;
    logic        m_ready       = 1'b0;
    wire  [31:0] m_relocated_word;
    wire         m_ok;
    wire  [2:0]  m_insn_class;

    // relocations predicted at input beats, waiting for their result beats
    reloc_result_t pending_relocs[$];
    int            mismatch_count = 0;
    // random idling on both sides while set
    bit            idle_on        = 1'b1;
    int            rx_hold        = 0;

    localparam logic [63:0] SITE = 64'h0000_0040_0000_1000;

    arm64_pc_relative_relocator u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_instr_word    (s_instr_word),
        .s_old_address   (s_old_address),
        .s_new_address   (s_new_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_relocated_word(m_relocated_word),
        .m_ok            (m_ok),
        .m_insn_class    (m_insn_class)
    );

    // 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // true if span, read as signed, lies in [-2^lg, 2^lg)
    function automatic bit fits_signed(logic [63:0] span, int unsigned lg);
        logic [63:0] half;
        half = 64'd1 << lg;
        return (span + half) < (half << 1);
    endfunction

    // expected relocation of one instruction word moved from pc_old to pc_new
    function automatic reloc_result_t relocate_insn(logic [31:0] w, logic [63:0] pc_old,
                                                    logic [63:0] pc_new);
        reloc_result_t r;
        logic [63:0]   disp;
        logic [31:0]   word;
        bit            good;
        insn_class_t   cls;
        word = w;
        good = 1'b1;
        cls  = CLS_OTHER;
        disp = '0;
        if ((w & B_BL_MASK) == B_BL_MATCH) begin
            // imm26 word offset, +-128 MB
            cls  = CLS_B_BL;
            disp = pc_old + {{36{w[25]}}, w[25:0], 2'b00} - pc_new;
            good = fits_signed(disp, 27) && disp[1:0] == 2'b00;
            word = {w[31:26], disp[27:2]};
        end else if ((w & B_COND_MASK) == B_COND_MATCH || (w & CB_TB_MASK) == CBZ_MATCH ||
                     (w & LDR_LIT_MASK) == LDR_LIT_MATCH) begin
            // imm19 word offset in bits 23:5, +-1 MB
            if ((w & B_COND_MASK) == B_COND_MATCH) begin
                cls = CLS_B_COND;
            end else if ((w & CB_TB_MASK) == CBZ_MATCH) begin
                cls = CLS_CBZ;
            end else begin
                cls = CLS_LDR_LIT;
            end
            disp = pc_old + {{43{w[23]}}, w[23:5], 2'b00} - pc_new;
            good = fits_signed(disp, 20) && disp[1:0] == 2'b00;
            word = {w[31:24], disp[20:2], w[4:0]};
        end else if ((w & CB_TB_MASK) == TBZ_MATCH) begin
            // imm14 word offset in bits 18:5, +-32 KB
            cls  = CLS_TBZ;
            disp = pc_old + {{48{w[18]}}, w[18:5], 2'b00} - pc_new;
            good = fits_signed(disp, 15) && disp[1:0] == 2'b00;
            word = {w[31:19], disp[15:2], w[4:0]};
        end else if ((w & ADR_MASK) == ADR_MATCH) begin
            // byte offset, immhi:immlo, any alignment
            cls  = CLS_ADR;
            disp = pc_old + {{43{w[23]}}, w[23:5], w[30:29]} - pc_new;
            good = fits_signed(disp, 20);
            word = {w[31], disp[1:0], w[28:24], disp[20:2], w[4:0]};
        end else if ((w & ADR_MASK) == ADRP_MATCH) begin
            // page offset, only the page bits of both addresses count
            cls  = CLS_ADRP;
            disp = (pc_old & PAGE_MASK) + {{31{w[23]}}, w[23:5], w[30:29], 12'h000}
                   - (pc_new & PAGE_MASK);
            good = fits_signed(disp, 32);
            word = {w[31], disp[13:12], w[28:24], disp[32:14], w[4:0]};
        end
        r.word = good ? word : 32'h0;
        r.ok   = good;
        r.cls  = cls;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    // receiver: stalls in random bursts while idling is on
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_hold <= $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // predict on every input beat, then check every result beat against the oldest
    // prediction; both in one block so the order within the edge is fixed
    always @(posedge aclk) begin : result_check
        reloc_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_relocs.push_back(relocate_insn(s_instr_word, s_old_address,
                                                       s_new_address));
            end
            if (m_valid && m_ready) begin
                if (pending_relocs.size() == 0) begin
                    report_mismatch($sformatf("result beat %h with nothing pending",
                                              m_relocated_word));
                end else begin
                    want = pending_relocs.pop_front();
                    if (m_relocated_word !== want.word) begin
                        report_mismatch($sformatf("relocated_word %h, want %h",
                                                  m_relocated_word, want.word));
                    end
                    if (m_ok !== want.ok) begin
                        report_mismatch($sformatf("ok %b, want %b (word %h)",
                                                  m_ok, want.ok, want.word));
                    end
                    if (m_insn_class !== want.cls) begin
                        report_mismatch($sformatf("insn_class %0d, want %s",
                                                  m_insn_class, want.cls.name()));
                    end
                end
            end
        end
    end

    // one input beat, with an optional idle burst before it; returns at the
    // edge where the beat is taken, leaving valid high
    task automatic send_insn(input logic [31:0] w, input logic [63:0] pc_old,
                             input logic [63:0] pc_new);
        int gap_len;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap_len = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap_len) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_instr_word  <= w;
        s_old_address <= pc_old;
        s_new_address <= pc_new;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // sender goes quiet until every pending relocation has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_relocs.size() != 0) @(posedge aclk);
    endtask

    // mostly well-formed pc-relative words with moves of assorted reach,
    // the rest raw noise with unrelated addresses
    task automatic random_code_burst(input int n_items);
        logic [31:0]  w;
        logic [63:0]  pc_old;
        logic [63:0]  delta;
        insn_class_t  pick;
        int unsigned  reach;
        repeat (n_items) begin
            w      = $urandom;
            pc_old = {$urandom, $urandom};
            if ($urandom_range(0, 99) < 85) begin
                pick = insn_class_t'($urandom_range(1, 7));
                case (pick)
                    CLS_B_BL:   w = (w & ~B_BL_MASK) | B_BL_MATCH;
                    CLS_B_COND: w = (w & ~B_COND_MASK) | B_COND_MATCH;
                    CLS_CBZ:    w = (w & ~CB_TB_MASK) | CBZ_MATCH;
                    CLS_TBZ:    w = (w & ~CB_TB_MASK) | TBZ_MATCH;
                    CLS_ADR:    w = (w & ~ADR_MASK) | ADR_MATCH;
                    CLS_ADRP:   w = (w & ~ADR_MASK) | ADRP_MATCH;
                    default:    w = (w & ~LDR_LIT_MASK) | LDR_LIT_MATCH;
                endcase
                // move distance scaled around the reach of each form
                case ($urandom_range(0, 6))
                    0:       reach = 8;
                    1:       reach = 15;
                    2:       reach = 20;
                    3:       reach = 27;
                    4:       reach = 32;
                    5:       reach = 40;
                    default: reach = 64;
                endcase
                delta = {$urandom, $urandom} >> (64 - reach);
                if ($urandom_range(0, 1) == 1) begin
                    delta = -delta;
                end
                if ($urandom_range(0, 7) != 0) begin
                    pc_old[1:0] = 2'b00;
                    delta[1:0]  = 2'b00;
                end
                send_insn(w, pc_old, pc_old + delta);
            end else begin
                send_insn(w, pc_old, {$urandom, $urandom});
            end
        end
    endtask

    // b, bl, b.cond, cbz/cbnz, tbz/tbnz at the edges of their reach
    task automatic test_branch_reach();
        send_insn(32'h15FF_FFFF, SITE, SITE);                  // b, largest forward imm26
        send_insn(32'h9600_0000, SITE, SITE);                  // bl, largest backward imm26
        send_insn(32'h1400_0000, 64'h0800_0000, 64'h0);        // one past +128 MB
        send_insn(32'h9400_0000, 64'h0, 64'h0800_0000);        // exactly -128 MB
        send_insn(32'h1400_0000, SITE, SITE + 64'd2);          // misaligned new address
        send_insn(32'h5400_0001, SITE + 64'h000F_FFFC, SITE);  // b.ne, top of imm19 reach
        send_insn(32'h5400_000B, SITE + 64'h0010_0000, SITE);  // b.lt, one past reach
        send_insn(32'h5400_0010, SITE, SITE + 64'd8);          // bit 4 set: not a b.cond
        send_insn(32'h3480_0000, SITE, SITE);                  // cbz, most negative imm19
        send_insn(32'hB500_0000, 64'h0, 64'hFFFF_FFFF_FFFF_FFFC); // cbnz, address wrap
        send_insn(32'h3603_FFE0, SITE, SITE - 64'd4);          // tbz, one past +32 KB
        send_insn(32'hB704_0000, SITE, SITE);                  // tbnz, most negative imm14
    endtask

    // adr takes any byte offset; adrp only sees page bits
    task automatic test_adr_adrp();
        send_insn(32'h3000_0000, SITE, SITE + 64'd3);          // adr immlo 1, odd move
        send_insn(32'h1000_0000, SITE + 64'h000F_FFFF, SITE);  // adr, top of reach
        send_insn(32'h1000_0000, SITE + 64'h0010_0000, SITE);  // adr, one past reach
        send_insn(32'h9000_0000, SITE + 64'hFFF, SITE - 64'h1_0000_0000); // page diff +2^32
        send_insn(32'hF000_0000, SITE, SITE + 64'h1_0000_0FFF); // adrp, near -2^32 bytes
        send_insn(32'h90FF_FFE0, 64'hFFFF_FFFF_FFFF_F123, 64'h0); // adrp, wrap past zero
    endtask

    // load-literal class: gp, prefetch and simd forms
    task automatic test_literal_loads();
        send_insn(32'h1800_0000, SITE + 64'h40, SITE);         // ldr w, short forward
        send_insn(32'h5880_0000, SITE, SITE);                  // ldr x, most negative imm19
        send_insn(32'hD800_0020, SITE, SITE - 64'h8_0000);     // prfm
        send_insn(32'h1C7F_FFE0, SITE, SITE + 64'h4);          // ldr s, largest imm19
        send_insn(32'h9C00_0000, SITE + 64'd1, SITE);          // ldr q, misaligned old address
    endtask

    // words outside every pc-relative form come back as they went in
    task automatic test_passthrough();
        send_insn(32'hD503_201F, SITE, 64'h0);                 // nop
        send_insn(32'h0000_0000, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_insn(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    endtask

    task automatic test_random_with_idling();
        idle_on = 1'b1;
        random_code_burst(450);
    endtask

    task automatic test_random_back_to_back();
        idle_on = 1'b0;
        random_code_burst(200);
    endtask

    // sender holds off until the pipeline is empty, then refills it
    task automatic test_drain_pause();
        idle_on = 1'b1;
        repeat (4) begin
            random_code_burst(100);
            wait_drained();
        end
    endtask

    // last stretch: no idling on either side
    task automatic test_streaming_tail();
        idle_on = 1'b0;
        random_code_burst(350);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_branch_reach();
        test_adr_adrp();
        test_literal_loads();
        test_passthrough();
        test_random_with_idling();
        test_random_back_to_back();
        test_drain_pause();
        test_streaming_tail();

        // let everything in flight come out, then watch for stray beats
        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[arm64_pc_relative_relocator] OK");
        end else begin
            $display("[arm64_pc_relative_relocator] ERROR");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("[arm64_pc_relative_relocator] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/a64rel_pkg.sv
hw/rtl/a64rel_core.sv
hw/rtl/arm64_pc_relative_relocator.sv
hw/rtl/a64rel_checker.sv
tb/tb_arm64_pc_relative_relocator.sv
